@@ rtl/prcc_pkg.sv @@
// Shared types and constants for the persistent record CRC checker.
`timescale 1ns / 1ps
`default_nettype none

package prcc_pkg;

    localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [15:0] REGION_RESET = 16'd4096;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_ZERO_LEN = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_CRC_BAD  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CRC  = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] data_len;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/prcc_crc32.sv @@
// One-word update of the MSB-first CRC-32 with polynomial 0x04C11DB7.
`timescale 1ns / 1ps
`default_nettype none

module prcc_crc32 (
    input  wire logic [31:0] i_crc,
    input  wire logic [31:0] i_word,
    output logic      [31:0] o_crc
);
    import prcc_pkg::*;

    // The bit loop flattens into a fixed XOR network over the 64 input bits.
    always_comb begin
        logic [31:0] c;
        c = i_crc ^ i_word;
        for (int b = 0; b < 32; b++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

@@ rtl/prcc_core.sv @@
// Record state, length check, CRC accumulation and result decision.
`timescale 1ns / 1ps
`default_nettype none

module prcc_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic [31:0]          i_word,
    input  wire logic                 i_start,
    input  wire logic [15:0]          i_region,
    output prcc_pkg::t_result         o_result
);
    import prcc_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [31:0] r_crc,    n_crc;
    logic [15:0] r_count,  n_count;
    logic [15:0] r_target, n_target;
    logic [31:0] r_len,    n_len;

    logic [31:0] crc_in;
    logic [31:0] crc_next;
    logic [32:0] aligned;
    logic        too_long;
    logic [15:0] target;
    logic        more;

    assign crc_in   = i_start ? CRC_INIT : r_crc;
    assign aligned  = ({1'b0, i_word} + 33'd7) & ~33'd7;
    assign too_long = ({1'b0, aligned} + 34'd8) > {18'd0, i_region};
    assign target   = aligned[17:2] + 16'd1;
    assign more     = r_count < r_target;

    prcc_crc32 u_crc (
        .i_crc  (crc_in),
        .i_word (i_word),
        .o_crc  (crc_next)
    );

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_count  = r_count;
        n_target = r_target;
        n_len    = r_len;
        if (i_en) begin
            if (i_start) begin
                n_len   = i_word;
                n_crc   = CRC_INIT;
                n_count = 16'd0;
                if (i_word == 32'd0 || too_long) begin
                    n_phase = PH_DONE;
                end else begin
                    n_crc    = crc_next;
                    n_count  = 16'd1;
                    n_target = target;
                    n_phase  = PH_CRC;
                end
            end else begin
                case (r_phase)
                    PH_CRC: begin
                        if (more) begin
                            n_crc   = crc_next;
                            n_count = r_count + 16'd1;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_IDLE, PH_DONE: begin
                        n_phase = r_phase;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result = '0;
        if (i_en) begin
            if (i_start) begin
                if (i_word == 32'd0) begin
                    o_result.valid  = 1'b1;
                    o_result.status = ST_ZERO_LEN;
                end else if (too_long) begin
                    o_result.valid  = 1'b1;
                    o_result.status = ST_TOO_LONG;
                end
            end else begin
                case (r_phase)
                    PH_CRC: begin
                        if (!more) begin
                            o_result.valid = 1'b1;
                            if (r_crc == i_word) begin
                                o_result.status   = ST_VALID;
                                o_result.data_len = r_len;
                            end else begin
                                o_result.status = ST_CRC_BAD;
                            end
                        end
                    end
                    default: begin
                        o_result.valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_crc    <= CRC_INIT;
            r_count  <= 16'd0;
            r_target <= 16'd0;
            r_len    <= 32'd0;
        end else begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_count  <= n_count;
            r_target <= n_target;
            r_len    <= n_len;
        end
    end

endmodule

`default_nettype wire

@@ rtl/persistent_record_crc_checker.sv @@
// Top level of the persistent record CRC checker: ports, input and result registers.
//
// Channel     Direction  Ports             Contents
// s_axis      in         tdata[31:0]       data_word
//                        tuser             record_start
// m_axis      out        tdata[39:0]       status[1:0], data_len[33:2], zero pad
// cfg         in         i_cfg_data[15:0]  region_bytes
//
// One word is accepted per cycle while the result is not stalled; a record's deciding word
// passes the input register, then its result is held in the result register.
// The rate is set by the combinational 32-bit CRC update in the core.
// Reset is synchronous and active low; the region size returns to 4096 bytes.
// A stalled result holds the input register, which then stalls the input side.
`timescale 1ns / 1ps
`default_nettype none

module persistent_record_crc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // data_word
    input  wire logic        i_s_axis_tuser,  // record_start
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [39:0] o_m_axis_tdata,  // status[1:0], data_len[33:2], zeros
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    import prcc_pkg::*;

    logic        r_s1_valid;
    logic [31:0] r_s1_word;
    logic        r_s1_start;
    logic [15:0] r_region;
    logic        r_out_valid;
    t_status     r_out_status;
    logic [31:0] r_out_len;

    logic        s1_go;
    logic        s1_fire;
    logic        in_fire;
    t_result     result;

    assign s1_go           = !r_out_valid || i_m_axis_tready;
    assign s1_fire         = r_s1_valid && s1_go;
    assign o_s_axis_tready = !r_s1_valid || s1_go;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    prcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (s1_fire),
        .i_word   (r_s1_word),
        .i_start  (r_s1_start),
        .i_region (r_region),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= REGION_RESET;
        end else if (i_cfg_valid) begin
            r_region <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_word  <= i_s_axis_tdata;
            r_s1_start <= i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && result.valid) begin
            r_out_status <= result.status;
            r_out_len    <= result.data_len;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_len, r_out_status};

endmodule

`default_nettype wire
